// File: rtl/core/sil_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sil_pkg : shared types and codes for the sorted insert list
// command and status codes, cell control types and field widths
// ----------------------------------------------------------------------------
package sil_pkg;

    localparam int VALUE_W  = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SORTED_INS = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // what every cell does on a command
    typedef enum logic [2:0] {
        KIND_NONE       = 3'd0,
        KIND_INS_FRONT  = 3'd1,
        KIND_INS_BACK   = 3'd2,
        KIND_INS_SEARCH = 3'd3,
        KIND_DEL_FRONT  = 3'd4,
        KIND_DEL_BACK   = 3'd5,
        KIND_DEL_SEARCH = 3'd6
    } kind_t;

    // broadcast to all cells
    typedef struct packed {
        kind_t kind;
        logic  use_ge;   // search for first entry not below value, else equal
    } ctl_t;

    // position of one cell relative to the fill level
    typedef struct packed {
        logic occ;       // cell holds a live entry
        logic first;     // cell is the head position
        logic at_end;    // cell is the first free position
    } place_t;

endpackage
`default_nettype wire

// File: rtl/core/sorted_insert_list.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_insert_list : ordered list of signed values in a row of cells
// push front/back, sorted insert, pop front/back and delete by value
// ----------------------------------------------------------------------------
// The list is a row of DEPTH cells, each holding one value; entry 0 is the
// head. Every command is carried out in the cycle of its input transfer: all
// cells compare their value with the command value at once, a hit flag
// ripples along the row to find the first match, and every cell then keeps
// its value, loads the new one or takes its left or right neighbour's value.
// One command is accepted per cycle: the finishing stage lets the next
// command in while a result waits, and in_stall rises only when it holds
// one too and out_stall is set. Its result (status, count, head and tail)
// goes through one finishing stage and the output register. The clock
// limit is set by the compare and the hit chain across all DEPTH cells.
// Entries come out of reset unwritten and no clearing pass is run: only
// the fill count is reset. A push on a full list reports full, a pop or
// delete on an empty list reports empty, a delete with no equal entry
// reports not found; unused command codes do nothing and report done.
// ----------------------------------------------------------------------------
module sorted_insert_list
#(
    parameter int DEPTH = 16
)
(
    input  wire                                      clk,
    input  wire                                      rst_n,
    // command channel
    input  wire                                      in_valid,
    output logic                                     in_stall,
    input  wire logic [sil_pkg::CMD_W-1:0]           cmd,
    input  wire logic signed [sil_pkg::VALUE_W-1:0]  value,
    // result channel
    output logic                                     out_valid,
    input  wire                                      out_stall,
    output logic [sil_pkg::STATUS_W-1:0]             status,
    output logic [sil_pkg::COUNT_W-1:0]              count,
    output logic signed [sil_pkg::VALUE_W-1:0]       head_value,
    output logic signed [sil_pkg::VALUE_W-1:0]       tail_value
);

    localparam int UW = $clog2(DEPTH + 1);

    // fill level
    logic [UW-1:0]                      used_reg;
    logic [UW-1:0]                      used_next;

    // finishing stage and output register
    logic                               fin_reg;
    logic [sil_pkg::STATUS_W-1:0]       fin_status_reg;
    logic                               out_valid_reg;
    logic [sil_pkg::STATUS_W-1:0]       out_status_reg;
    logic [sil_pkg::COUNT_W-1:0]        out_count_reg;
    logic signed [sil_pkg::VALUE_W-1:0] out_head_reg;
    logic signed [sil_pkg::VALUE_W-1:0] out_tail_reg;

    // row
    logic signed [sil_pkg::VALUE_W-1:0] cell_entry [DEPTH];
    logic                               seen [DEPTH+1];
    sil_pkg::place_t                    place [DEPTH];
    sil_pkg::ctl_t                      ctl;

    logic                               accept;
    logic                               fin_move;
    logic                               empty;
    logic                               full;
    logic                               found;
    logic signed [sil_pkg::VALUE_W-1:0] head_cur;
    logic signed [sil_pkg::VALUE_W-1:0] tail_cur;
    sil_pkg::kind_t                     kind_dec;
    logic [sil_pkg::STATUS_W-1:0]       status_dec;
    logic [UW+sil_pkg::COUNT_W-1:0]     count_wide;

    assign accept   = in_valid & !in_stall;
    // finished result moves into the output register when that is free
    assign fin_move = fin_reg & (!out_valid_reg | !out_stall);
    assign in_stall = fin_reg & out_valid_reg & out_stall;

    assign empty    = (used_reg == '0);
    assign full     = (used_reg == UW'(DEPTH));
    assign head_cur = cell_entry[0];

    // tail is the cell just below the fill level
    always_comb
    begin
        tail_cur = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (used_reg == UW'(i + 1))
            begin
                tail_cur = tail_cur | cell_entry[i];
            end
        end
    end

    assign seen[0] = 1'b0;
    assign found   = seen[DEPTH];

    // decode the command against head, tail and the search result
    always_comb
    begin
        kind_dec   = sil_pkg::KIND_NONE;
        status_dec = sil_pkg::ST_DONE;
        unique case (cmd)
            sil_pkg::CMD_PUSH_FRONT, sil_pkg::CMD_PUSH_BACK, sil_pkg::CMD_SORTED_INS:
            begin
                if (full)
                begin
                    status_dec = sil_pkg::ST_FULL;
                end
                else if (cmd == sil_pkg::CMD_PUSH_FRONT)
                begin
                    kind_dec = sil_pkg::KIND_INS_FRONT;
                end
                else if (cmd == sil_pkg::CMD_PUSH_BACK)
                begin
                    kind_dec = sil_pkg::KIND_INS_BACK;
                end
                else if (empty || (value < head_cur))
                begin
                    kind_dec = sil_pkg::KIND_INS_FRONT;
                end
                else if (!(value < tail_cur))
                begin
                    kind_dec = sil_pkg::KIND_INS_BACK;
                end
                else
                begin
                    kind_dec = sil_pkg::KIND_INS_SEARCH;
                end
            end
            sil_pkg::CMD_POP_FRONT, sil_pkg::CMD_POP_BACK, sil_pkg::CMD_DELETE:
            begin
                if (empty)
                begin
                    status_dec = sil_pkg::ST_EMPTY;
                end
                else if (cmd == sil_pkg::CMD_POP_FRONT)
                begin
                    kind_dec = sil_pkg::KIND_DEL_FRONT;
                end
                else if (cmd == sil_pkg::CMD_POP_BACK)
                begin
                    kind_dec = sil_pkg::KIND_DEL_BACK;
                end
                else if (head_cur == value)
                begin
                    kind_dec = sil_pkg::KIND_DEL_FRONT;
                end
                else if (tail_cur == value)
                begin
                    kind_dec = sil_pkg::KIND_DEL_BACK;
                end
                else if (found)
                begin
                    kind_dec = sil_pkg::KIND_DEL_SEARCH;
                end
                else
                begin
                    status_dec = sil_pkg::ST_MISSING;
                end
            end
            default:
            begin
                kind_dec   = sil_pkg::KIND_NONE;
                status_dec = sil_pkg::ST_DONE;
            end
        endcase
    end

    // cells only move on an input transfer
    assign ctl.kind   = accept ? kind_dec : sil_pkg::KIND_NONE;
    assign ctl.use_ge = (cmd == sil_pkg::CMD_SORTED_INS);

    always_comb
    begin
        used_next = used_reg;
        unique case (ctl.kind)
            sil_pkg::KIND_INS_FRONT, sil_pkg::KIND_INS_BACK, sil_pkg::KIND_INS_SEARCH:
                used_next = used_reg + UW'(1);
            sil_pkg::KIND_DEL_FRONT, sil_pkg::KIND_DEL_BACK, sil_pkg::KIND_DEL_SEARCH:
                used_next = used_reg - UW'(1);
            default:
                used_next = used_reg;
        endcase
    end

    // row of cells, neighbours wired left and right
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic signed [sil_pkg::VALUE_W-1:0] left_entry;
        logic signed [sil_pkg::VALUE_W-1:0] right_entry;

        assign place[g].occ    = (used_reg > UW'(g));
        assign place[g].first  = (g == 0);
        assign place[g].at_end = (used_reg == UW'(g));

        if (g == 0)
        begin : g_left_edge
            assign left_entry = value;
        end
        else
        begin : g_left_inner
            assign left_entry = cell_entry[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_right_edge
            assign right_entry = cell_entry[g];
        end
        else
        begin : g_right_inner
            assign right_entry = cell_entry[g+1];
        end

        sil_cell u_cell
        (
            .clk         (clk),
            .ctl         (ctl),
            .place       (place[g]),
            .value       (value),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .seen_in     (seen[g]),
            .seen_out    (seen[g+1]),
            .entry       (cell_entry[g])
        );
    end

    // count port carries the low bits of the fill level
    assign count_wide = {{sil_pkg::COUNT_W{1'b0}}, used_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            if (accept)
            begin
                fin_reg <= 1'b1;
            end
            else if (fin_move)
            begin
                fin_reg <= 1'b0;
            end
            if (fin_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fin_status_reg <= status_dec;
        end
        if (fin_move)
        begin
            out_status_reg <= fin_status_reg;
            out_count_reg  <= count_wide[sil_pkg::COUNT_W-1:0];
            out_head_reg   <= empty ? '0 : head_cur;
            out_tail_reg   <= empty ? '0 : tail_cur;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign count      = out_count_reg;
    assign head_value = out_head_reg;
    assign tail_value = out_tail_reg;

    // fill level never passes the row length
    a_used_bound : assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(DEPTH))
        else $error("fill level beyond depth");

    // a rejected push leaves the list full
    a_full_holds : assert property (@(posedge clk) disable iff (!rst_n)
        accept && full && (cmd == sil_pkg::CMD_PUSH_FRONT || cmd == sil_pkg::CMD_PUSH_BACK
            || cmd == sil_pkg::CMD_SORTED_INS) |=> used_reg == UW'(DEPTH))
        else $error("full list changed on push");

    // a failed delete leaves the fill level alone
    a_missing_holds : assert property (@(posedge clk) disable iff (!rst_n)
        accept && status_dec == sil_pkg::ST_MISSING |=> used_reg == $past(used_reg))
        else $error("fill level changed on missing delete");

    // sorted search always lands before the tail
    a_search_found : assert property (@(posedge clk) disable iff (!rst_n)
        accept && kind_dec == sil_pkg::KIND_INS_SEARCH |-> found)
        else $error("sorted insert found no position");

    // an empty result reports zero head and tail
    a_empty_zero : assert property (@(posedge clk) disable iff (!rst_n)
        fin_move && empty |=> out_head_reg == '0 && out_tail_reg == '0)
        else $error("empty list reported nonzero head or tail");

endmodule
`default_nettype wire

// File: rtl/core/sil_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sil_cell : one entry of the sorted insert list
// holds a value, compares it with the broadcast value and shifts left/right
// ----------------------------------------------------------------------------
module sil_cell
(
    input  wire                                    clk,
    input  wire sil_pkg::ctl_t                     ctl,
    input  wire sil_pkg::place_t                   place,
    input  wire logic signed [sil_pkg::VALUE_W-1:0] value,
    input  wire logic signed [sil_pkg::VALUE_W-1:0] left_entry,
    input  wire logic signed [sil_pkg::VALUE_W-1:0] right_entry,
    input  wire logic                              seen_in,
    output logic                                   seen_out,
    output logic signed [sil_pkg::VALUE_W-1:0]     entry
);

    logic signed [sil_pkg::VALUE_W-1:0] entry_reg;
    logic signed [sil_pkg::VALUE_W-1:0] entry_next;
    logic                               hit;
    logic                               flag;

    // search hit, the head never takes part
    always_comb
    begin
        if (ctl.use_ge)
        begin
            hit = !(entry_reg < value);
        end
        else
        begin
            hit = (entry_reg == value);
        end
        flag     = place.occ & !place.first & hit;
        seen_out = seen_in | flag;
    end

    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctl.kind)
            sil_pkg::KIND_INS_FRONT:  entry_next = place.first ? value : left_entry;
            sil_pkg::KIND_INS_BACK:   entry_next = place.at_end ? value : entry_reg;
            sil_pkg::KIND_INS_SEARCH:
            begin
                if (seen_in)
                begin
                    entry_next = left_entry;
                end
                else if (flag)
                begin
                    entry_next = value;
                end
            end
            sil_pkg::KIND_DEL_FRONT:  entry_next = right_entry;
            sil_pkg::KIND_DEL_SEARCH: entry_next = seen_out ? right_entry : entry_reg;
            default:                  entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
`default_nettype wire
